>>> design/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, constants, datapath operation codes and the status flags
// that the datapath reports to the microcode sequencer.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int ACC_BITS    = 56;
  localparam int REM_BITS    = ACC_BITS + 1;
  localparam int CLOSE_BITS  = 32;
  localparam int PERIOD_BITS = 8;
  localparam int SEEN_BITS   = 9;
  localparam int RSI_BITS    = 14;

  localparam int PRICE_BITS_DEFAULT = 32;
  localparam int FRAC_BITS_DEFAULT  = 16;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd14;
  localparam logic [RSI_BITS-1:0]    RSI_SCALE    = 14'd10000;
  localparam logic [RSI_BITS-1:0]    RSI_NEUTRAL  = 14'd5000;

  // datapath operations, one per control word
  typedef logic [3:0] op_t;
  localparam op_t OP_TAKE        = 4'd0;
  localparam op_t OP_NOP         = 4'd1;
  localparam op_t OP_DIFF        = 4'd2;
  localparam op_t OP_ACCUM       = 4'd3;
  localparam op_t OP_SEED_LOAD   = 4'd4;
  localparam op_t OP_SMOOTH_MUL  = 4'd5;
  localparam op_t OP_SMOOTH_LOAD = 4'd6;
  localparam op_t OP_DIV_STEP    = 4'd7;
  localparam op_t OP_STORE_AVG   = 4'd8;
  localparam op_t OP_RATIO_LOAD  = 4'd9;
  localparam op_t OP_SET_RATIO   = 4'd10;
  localparam op_t OP_SET_FULL    = 4'd11;
  localparam op_t OP_SET_NEUTRAL = 4'd12;
  localparam op_t OP_OUT         = 4'd13;

  typedef struct packed {
    logic req;
    logic seen_zero;
    logic seeded;
    logic seen_eq_p;
    logic cnt_nz;
    logic loss_zero;
    logic out_busy;
  } flags_t;

endpackage

>>> design/rsi_div_lane.sv
// ----------------------------------------------------------------------------
// rsi_div_lane
// Restoring divider lane, one quotient bit per step. The dividend shifts out
// of the quotient register into the partial remainder.
// ----------------------------------------------------------------------------
module rsi_div_lane (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [rsi_pkg::REM_BITS-1:0]  rem_init,
  input  logic [rsi_pkg::ACC_BITS-1:0]  quo_init,
  input  logic [rsi_pkg::REM_BITS-1:0]  div_init,
  output logic [rsi_pkg::ACC_BITS-1:0]  quo
);

  logic [rsi_pkg::REM_BITS-1:0] rem;
  logic [rsi_pkg::REM_BITS-1:0] divisor;
  logic [rsi_pkg::REM_BITS:0]   rem_sh;
  logic [rsi_pkg::REM_BITS:0]   rem_sub;
  logic                         fits;

  assign rem_sh  = {rem, quo[rsi_pkg::ACC_BITS-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (load) begin
      rem     <= rem_init;
      quo     <= quo_init;
      divisor <= div_init;
    end else if (step) begin
      rem <= fits ? rem_sub[rsi_pkg::REM_BITS-1:0] : rem_sh[rsi_pkg::REM_BITS-1:0];
      quo <= {quo[rsi_pkg::ACC_BITS-2:0], fits};
    end
  end

endmodule

>>> design/rsi_datapath.sv
// ----------------------------------------------------------------------------
// rsi_datapath
// Price history, running averages, two divider lanes and the result and
// output registers, all driven by the operation code of the current step.
// ----------------------------------------------------------------------------
module rsi_datapath #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEFAULT,
  parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rsi_pkg::op_t                     op,
  output rsi_pkg::flags_t                  flags,
  input  logic                             price_valid,
  output logic                             price_stall,
  input  logic [rsi_pkg::CLOSE_BITS-1:0]   close_price,
  output logic                             rsi_valid,
  input  logic                             rsi_stall,
  output logic [rsi_pkg::RSI_BITS-1:0]     rsi_centi,
  output logic                             rsi_ready,
  input  logic                             cfg_valid,
  input  logic [rsi_pkg::PERIOD_BITS-1:0]  rsi_period
);

  localparam int PW = (PRICE_BITS < rsi_pkg::CLOSE_BITS) ? PRICE_BITS : rsi_pkg::CLOSE_BITS;
  localparam int ACC = rsi_pkg::ACC_BITS;
  localparam int PB = rsi_pkg::PERIOD_BITS;
  localparam int MUL_BITS = ACC + PB;
  localparam int PROD_BITS = ACC + rsi_pkg::RSI_BITS;
  localparam int CNT_BITS = $clog2(ACC);
  localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(ACC - 1);
  localparam logic [CNT_BITS-1:0] RATIO_LAST = CNT_BITS'(rsi_pkg::RSI_BITS - 1);

  logic [PB-1:0]                    period;
  logic [PW-1:0]                    price;
  logic [PW-1:0]                    prev;
  logic [rsi_pkg::SEEN_BITS-1:0]    seen;
  logic [ACC-1:0]                   run_gain;
  logic [ACC-1:0]                   run_loss;
  logic [ACC-1:0]                   gain;
  logic [ACC-1:0]                   loss;
  logic [CNT_BITS-1:0]              cnt;
  logic [rsi_pkg::RSI_BITS-1:0]     res_rsi;
  logic                             res_ready;

  logic [PB-1:0]                    p;
  logic [PB-1:0]                    p_less;
  logic [rsi_pkg::SEEN_BITS-1:0]    p_plus;
  logic [PW-1:0]                    rise;
  logic [PW-1:0]                    fall;
  logic [MUL_BITS-1:0]              mul_gain;
  logic [MUL_BITS-1:0]              mul_loss;
  logic [PROD_BITS-1:0]             prod;

  logic                             load_a;
  logic                             load_b;
  logic                             div_step;
  logic [rsi_pkg::REM_BITS-1:0]     rem_init_a;
  logic [ACC-1:0]                   quo_init_a;
  logic [rsi_pkg::REM_BITS-1:0]     div_init_a;
  logic [ACC-1:0]                   quo_init_b;
  logic [rsi_pkg::REM_BITS-1:0]     div_init_p;
  logic [ACC-1:0]                   quo_a;
  logic [ACC-1:0]                   quo_b;

  // a period of zero behaves as one
  assign p        = (period == '0) ? PB'(1) : period;
  assign p_less   = p - PB'(1);
  assign p_plus   = {1'b0, p} + rsi_pkg::SEEN_BITS'(1);
  assign rise     = price - prev;
  assign fall     = prev - price;
  assign mul_gain = MUL_BITS'(run_gain) * MUL_BITS'(p_less);
  assign mul_loss = MUL_BITS'(run_loss) * MUL_BITS'(p_less);
  assign prod     = PROD_BITS'(run_gain) * PROD_BITS'(rsi_pkg::RSI_SCALE);

  assign flags.req       = price_valid;
  assign flags.seen_zero = seen == '0;
  assign flags.seeded    = seen >= p_plus;
  assign flags.seen_eq_p = seen == {1'b0, p};
  assign flags.cnt_nz    = cnt != '0;
  assign flags.loss_zero = run_loss == '0;
  assign flags.out_busy  = rsi_valid & rsi_stall;

  assign price_stall = op != rsi_pkg::OP_TAKE;

  // lane loads for the average divisions and for the ratio
  assign div_init_p = rsi_pkg::REM_BITS'(p);
  assign load_b     = (op == rsi_pkg::OP_SEED_LOAD) | (op == rsi_pkg::OP_SMOOTH_LOAD);
  assign load_a     = load_b | (op == rsi_pkg::OP_RATIO_LOAD);
  assign div_step   = op == rsi_pkg::OP_DIV_STEP;

  always_comb begin
    case (op)
      rsi_pkg::OP_SEED_LOAD: begin
        rem_init_a = '0;
        quo_init_a = run_gain;
        div_init_a = div_init_p;
        quo_init_b = run_loss;
      end
      rsi_pkg::OP_SMOOTH_LOAD: begin
        rem_init_a = '0;
        quo_init_a = run_gain + gain;
        div_init_a = div_init_p;
        quo_init_b = run_loss + loss;
      end
      default: begin
        // high part of the scaled gain stays below the divisor
        rem_init_a = rsi_pkg::REM_BITS'(prod[PROD_BITS-1:rsi_pkg::RSI_BITS]);
        quo_init_a = {prod[rsi_pkg::RSI_BITS-1:0], {(ACC-rsi_pkg::RSI_BITS){1'b0}}};
        div_init_a = {1'b0, run_gain} + {1'b0, run_loss};
        quo_init_b = run_loss + loss;
      end
    endcase
  end

  rsi_div_lane u_lane_a (
    .clk      (clk),
    .load     (load_a),
    .step     (div_step),
    .rem_init (rem_init_a),
    .quo_init (quo_init_a),
    .div_init (div_init_a),
    .quo      (quo_a)
  );

  rsi_div_lane u_lane_b (
    .clk      (clk),
    .load     (load_b),
    .step     (div_step),
    .rem_init ('0),
    .quo_init (quo_init_b),
    .div_init (div_init_p),
    .quo      (quo_b)
  );

  // history and averages, cleared by reset and by a period write
  always_ff @(posedge clk) begin
    if (rst) begin
      period   <= rsi_pkg::PERIOD_RESET;
      prev     <= '0;
      seen     <= '0;
      run_gain <= '0;
      run_loss <= '0;
    end else if (cfg_valid) begin
      period   <= rsi_period;
      prev     <= '0;
      seen     <= '0;
      run_gain <= '0;
      run_loss <= '0;
    end else begin
      case (op)
        rsi_pkg::OP_DIFF: begin
          prev <= price;
          if (seen == '0) begin
            seen <= rsi_pkg::SEEN_BITS'(1);
          end
        end
        rsi_pkg::OP_ACCUM: begin
          run_gain <= run_gain + gain;
          run_loss <= run_loss + loss;
          seen     <= seen + rsi_pkg::SEEN_BITS'(1);
        end
        rsi_pkg::OP_SMOOTH_MUL: begin
          run_gain <= mul_gain[ACC-1:0];
          run_loss <= mul_loss[ACC-1:0];
        end
        rsi_pkg::OP_STORE_AVG: begin
          run_gain <= quo_a;
          run_loss <= quo_b;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      rsi_pkg::OP_TAKE: begin
        price <= close_price[PW-1:0];
      end
      rsi_pkg::OP_DIFF: begin
        if (price > prev) begin
          gain <= ACC'(rise) << FRAC_BITS;
          loss <= '0;
        end else begin
          gain <= '0;
          loss <= ACC'(fall) << FRAC_BITS;
        end
      end
      rsi_pkg::OP_SEED_LOAD, rsi_pkg::OP_SMOOTH_LOAD: begin
        cnt <= DIV_LAST;
      end
      rsi_pkg::OP_RATIO_LOAD: begin
        cnt <= RATIO_LAST;
      end
      rsi_pkg::OP_DIV_STEP: begin
        cnt <= cnt - CNT_BITS'(1);
      end
      rsi_pkg::OP_SET_RATIO: begin
        res_rsi   <= quo_a[rsi_pkg::RSI_BITS-1:0];
        res_ready <= 1'b1;
      end
      rsi_pkg::OP_SET_FULL: begin
        res_rsi   <= rsi_pkg::RSI_SCALE;
        res_ready <= 1'b1;
      end
      rsi_pkg::OP_SET_NEUTRAL: begin
        res_rsi   <= rsi_pkg::RSI_NEUTRAL;
        res_ready <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // output register, loaded only once the previous request has gone
  always_ff @(posedge clk) begin
    if (rst) begin
      rsi_valid <= 1'b0;
    end else if ((op == rsi_pkg::OP_OUT) && !(rsi_valid && rsi_stall)) begin
      rsi_valid <= 1'b1;
    end else if (rsi_valid && !rsi_stall) begin
      rsi_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((op == rsi_pkg::OP_OUT) && !(rsi_valid && rsi_stall)) begin
      rsi_centi <= res_rsi;
      rsi_ready <= res_ready;
    end
  end

endmodule

>>> design/rsi_sequencer.sv
// ----------------------------------------------------------------------------
// rsi_sequencer
// Step counter and microcode table. Each control word names a datapath
// operation, a jump condition and a jump target; otherwise the step advances.
// ----------------------------------------------------------------------------
module rsi_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  rsi_pkg::flags_t flags,
  output rsi_pkg::op_t    op
);

  typedef logic [4:0] step_t;
  typedef logic [3:0] cond_t;

  typedef struct packed {
    rsi_pkg::op_t op;
    cond_t        cond;
    step_t        target;
  } uword_t;

  localparam cond_t C_NEVER     = 4'd0;
  localparam cond_t C_ALWAYS    = 4'd1;
  localparam cond_t C_NO_REQ    = 4'd2;
  localparam cond_t C_SEEN_ZERO = 4'd3;
  localparam cond_t C_SEEDED    = 4'd4;
  localparam cond_t C_SEEN_NE_P = 4'd5;
  localparam cond_t C_CNT_NZ    = 4'd6;
  localparam cond_t C_LOSS_ZERO = 4'd7;
  localparam cond_t C_OUT_BUSY  = 4'd8;

  localparam step_t S_IDLE      = 5'd0;
  localparam step_t S_DIFF      = 5'd1;
  localparam step_t S_BRANCH    = 5'd2;
  localparam step_t S_ACCUM     = 5'd3;
  localparam step_t S_SEED_LOAD = 5'd4;
  localparam step_t S_SMOOTH    = 5'd5;
  localparam step_t S_SM_LOAD   = 5'd6;
  localparam step_t S_DIV_LOOP  = 5'd7;
  localparam step_t S_STORE     = 5'd8;
  localparam step_t S_LOSS_TEST = 5'd9;
  localparam step_t S_RATIO     = 5'd10;
  localparam step_t S_RAT_LOOP  = 5'd11;
  localparam step_t S_SET_RATIO = 5'd12;
  localparam step_t S_SET_FULL  = 5'd13;
  localparam step_t S_SET_NEUT  = 5'd14;
  localparam step_t S_OUT       = 5'd15;
  localparam step_t S_RETURN    = 5'd16;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_IDLE:      w = '{rsi_pkg::OP_TAKE,        C_NO_REQ,    S_IDLE};
      S_DIFF:      w = '{rsi_pkg::OP_DIFF,        C_SEEN_ZERO, S_SET_NEUT};
      S_BRANCH:    w = '{rsi_pkg::OP_NOP,         C_SEEDED,    S_SMOOTH};
      S_ACCUM:     w = '{rsi_pkg::OP_ACCUM,       C_SEEN_NE_P, S_SET_NEUT};
      S_SEED_LOAD: w = '{rsi_pkg::OP_SEED_LOAD,   C_ALWAYS,    S_DIV_LOOP};
      S_SMOOTH:    w = '{rsi_pkg::OP_SMOOTH_MUL,  C_NEVER,     S_IDLE};
      S_SM_LOAD:   w = '{rsi_pkg::OP_SMOOTH_LOAD, C_NEVER,     S_IDLE};
      S_DIV_LOOP:  w = '{rsi_pkg::OP_DIV_STEP,    C_CNT_NZ,    S_DIV_LOOP};
      S_STORE:     w = '{rsi_pkg::OP_STORE_AVG,   C_NEVER,     S_IDLE};
      S_LOSS_TEST: w = '{rsi_pkg::OP_NOP,         C_LOSS_ZERO, S_SET_FULL};
      S_RATIO:     w = '{rsi_pkg::OP_RATIO_LOAD,  C_NEVER,     S_IDLE};
      S_RAT_LOOP:  w = '{rsi_pkg::OP_DIV_STEP,    C_CNT_NZ,    S_RAT_LOOP};
      S_SET_RATIO: w = '{rsi_pkg::OP_SET_RATIO,   C_ALWAYS,    S_OUT};
      S_SET_FULL:  w = '{rsi_pkg::OP_SET_FULL,    C_ALWAYS,    S_OUT};
      S_SET_NEUT:  w = '{rsi_pkg::OP_SET_NEUTRAL, C_NEVER,     S_IDLE};
      S_OUT:       w = '{rsi_pkg::OP_OUT,         C_OUT_BUSY,  S_OUT};
      S_RETURN:    w = '{rsi_pkg::OP_NOP,         C_ALWAYS,    S_IDLE};
      default:     w = '{rsi_pkg::OP_NOP,         C_ALWAYS,    S_IDLE};
    endcase
    return w;
  endfunction

  step_t  pc;
  step_t  pc_next;
  uword_t word;
  logic   take;

  assign word = ucode(pc);
  assign op   = word.op;

  always_comb begin
    case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_REQ:    take = !flags.req;
      C_SEEN_ZERO: take = flags.seen_zero;
      C_SEEDED:    take = flags.seeded;
      C_SEEN_NE_P: take = !flags.seen_eq_p;
      C_CNT_NZ:    take = flags.cnt_nz;
      C_LOSS_ZERO: take = flags.loss_zero;
      C_OUT_BUSY:  take = flags.out_busy;
      default:     take = 1'b1;
    endcase
    pc_next = take ? word.target : pc + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> design/relative_strength_index_unit.sv
// ----------------------------------------------------------------------------
// relative_strength_index_unit
// Wilder relative strength index over a stream of close prices.
// ----------------------------------------------------------------------------
// Usage:
// - price channel (price_valid, price_stall, close_price): one close per
//   request; the unit stalls while an item is being worked on.
// - result channel (rsi_valid, rsi_stall, rsi_centi, rsi_ready): one result
//   per price, held in an output register until taken.
// - cfg channel (cfg_valid, cfg_ready, rsi_period): cfg_ready is always high;
//   a write restarts seeding. Write only while the unit is idle.
// A microcode program runs per item, and the next price is accepted only
// once the program for the last one has returned to idle. The item that
// completes seeding and every smoothed item run two 56-step average
// divisions side by side in two divider lanes plus a 14-step ratio
// division; with zero average loss the ratio is skipped.
// Reset sets the period to 14 and clears the price history and averages.
// A stalled result holds; the next item is still worked on and waits in
// the output step until the register frees up.
// ----------------------------------------------------------------------------
module relative_strength_index_unit #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEFAULT,
  parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             price_valid,
  output logic                             price_stall,
  input  logic [rsi_pkg::CLOSE_BITS-1:0]   close_price,
  output logic                             rsi_valid,
  input  logic                             rsi_stall,
  output logic [rsi_pkg::RSI_BITS-1:0]     rsi_centi,
  output logic                             rsi_ready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsi_pkg::PERIOD_BITS-1:0]  rsi_period
);

  rsi_pkg::op_t    op;
  rsi_pkg::flags_t flags;

  assign cfg_ready = 1'b1;

  rsi_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (op)
  );

  rsi_datapath #(
    .PRICE_BITS (PRICE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .flags       (flags),
    .price_valid (price_valid),
    .price_stall (price_stall),
    .close_price (close_price),
    .rsi_valid   (rsi_valid),
    .rsi_stall   (rsi_stall),
    .rsi_centi   (rsi_centi),
    .rsi_ready   (rsi_ready),
    .cfg_valid   (cfg_valid),
    .rsi_period  (rsi_period)
  );

endmodule

>>> bench/tb_relative_strength_index_unit.sv
// ----------------------------------------------------------------------------
// tb_relative_strength_index_unit
// Self-checking bench for the Wilder RSI unit. Close prices go in from a
// backlog through a clocked driver; a predictor tracks price history and the
// seeding sums and averages and queues the expected RSI per request. A
// clocked monitor takes results under random stall and compares each field.
// Runs a short directed set, then trend-shaped price walks over several
// periods, including 0, 1 and 255.
// ----------------------------------------------------------------------------
module tb_relative_strength_index_unit;

  typedef struct {
    logic [rsi_pkg::RSI_BITS-1:0] centi;
    logic                         seeded;
  } rsi_result_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            price_valid = 1'b0;
  logic                            price_stall;
  logic [rsi_pkg::CLOSE_BITS-1:0]  close_price = '0;
  logic                            rsi_valid;
  logic                            rsi_stall = 1'b0;
  logic [rsi_pkg::RSI_BITS-1:0]    rsi_centi;
  logic                            rsi_ready;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rsi_pkg::PERIOD_BITS-1:0] cfg_period = '0;

  // predictor state
  logic [rsi_pkg::PERIOD_BITS-1:0] window_len = rsi_pkg::PERIOD_RESET;
  logic [rsi_pkg::CLOSE_BITS-1:0]  prev_close = '0;
  logic [rsi_pkg::SEEN_BITS-1:0]   seen_count = '0;
  logic [rsi_pkg::ACC_BITS-1:0]    avg_up = '0;
  logic [rsi_pkg::ACC_BITS-1:0]    avg_down = '0;

  logic [rsi_pkg::CLOSE_BITS-1:0]  close_backlog[$];
  rsi_result_t                     rsi_due[$];
  int                              fault_count = 0;
  int                              send_gap = 0;
  int                              send_calm = 0;
  int                              recv_left = 0;
  int                              recv_calm = 0;
  int unsigned                     cycle_no = 0;
  logic                            hold_active = 1'b0;
  rsi_result_t                     want;

  relative_strength_index_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .price_valid (price_valid),
    .price_stall (price_stall),
    .close_price (close_price),
    .rsi_valid   (rsi_valid),
    .rsi_stall   (rsi_stall),
    .rsi_centi   (rsi_centi),
    .rsi_ready   (rsi_ready),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .rsi_period  (cfg_period)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // one close price through the Wilder recurrence
  function automatic rsi_result_t wilder_rsi_next(
    input logic [rsi_pkg::CLOSE_BITS-1:0] close
  );
    logic [rsi_pkg::SEEN_BITS-1:0] span;
    logic [rsi_pkg::ACC_BITS-1:0]  div_by;
    logic [rsi_pkg::ACC_BITS-1:0]  keep;
    logic [rsi_pkg::ACC_BITS-1:0]  rise;
    logic [rsi_pkg::ACC_BITS-1:0]  fall;
    logic [79:0]                   scaled;
    logic [79:0]                   total;
    logic [79:0]                   ratio;
    rsi_result_t                   res;
    span = (window_len == '0) ? 9'd1 : {1'b0, window_len};
    div_by = rsi_pkg::ACC_BITS'(span);
    keep = div_by - rsi_pkg::ACC_BITS'(1);
    rise = '0;
    fall = '0;
    res.centi = rsi_pkg::RSI_NEUTRAL;
    res.seeded = 1'b0;
    if (seen_count == '0) begin
      prev_close = close;
      seen_count = 9'd1;
    end else begin
      if (close > prev_close) begin
        rise = {24'b0, close - prev_close} << rsi_pkg::FRAC_BITS_DEFAULT;
      end else begin
        fall = {24'b0, prev_close - close} << rsi_pkg::FRAC_BITS_DEFAULT;
      end
      prev_close = close;
      if (seen_count < span + 9'd1) begin
        avg_up = avg_up + rise;
        avg_down = avg_down + fall;
        seen_count = seen_count + 9'd1;
        // seeding done: sums become averages
        if (seen_count == span + 9'd1) begin
          avg_up = avg_up / div_by;
          avg_down = avg_down / div_by;
        end
      end else begin
        avg_up = avg_up * keep + rise;
        avg_up = avg_up / div_by;
        avg_down = avg_down * keep + fall;
        avg_down = avg_down / div_by;
      end
    end
    if (seen_count >= span + 9'd1) begin
      res.seeded = 1'b1;
      if (avg_down == '0) begin
        res.centi = rsi_pkg::RSI_SCALE;
      end else begin
        scaled = 80'(avg_up) * 80'd10000;
        total = 80'(avg_up) + 80'(avg_down);
        ratio = scaled / total;
        res.centi = ratio[rsi_pkg::RSI_BITS-1:0];
      end
    end
    return res;
  endfunction

  // price driver
  always @(posedge clk) begin
    if (rst) begin
      price_valid <= 1'b0;
      close_price <= '0;
      send_gap = 0;
    end else begin
      if (price_valid && !price_stall) rsi_due = {rsi_due, wilder_rsi_next(close_price)};
      if (!price_valid || !price_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          price_valid <= 1'b0;
        end else if (close_backlog.size() != 0) begin
          price_valid <= 1'b1;
          close_price <= close_backlog.pop_front();
          if (send_calm > 0) begin
            send_calm--;
            send_gap = 0;
          end else begin
            send_gap = $urandom_range(0, 1) ? gap_len() : 0;
            if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(20, 80);
          end
        end else begin
          price_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off on the result side so the unit backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      cycle_no <= 0;
      hold_active <= 1'b0;
    end else begin
      cycle_no <= cycle_no + 1;
      hold_active <= (cycle_no >= 5000 && cycle_no < 5600) ||
                     (cycle_no >= 60000 && cycle_no < 60800);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsi_stall <= 1'b0;
      recv_left = 0;
      recv_calm = 0;
    end else begin
      if (rsi_valid && !rsi_stall) begin
        if (rsi_due.size() == 0) begin
          $error("result with no request outstanding: rsi_centi %0d rsi_ready %0d",
                 rsi_centi, rsi_ready);
          fault_count++;
        end else begin
          want = rsi_due.pop_front();
          if (rsi_centi !== want.centi) begin
            $error("rsi_centi: expected %0d, got %0d", want.centi, rsi_centi);
            fault_count++;
          end
          if (rsi_ready !== want.seeded) begin
            $error("rsi_ready: expected %0d, got %0d", want.seeded, rsi_ready);
            fault_count++;
          end
        end
      end
      if (recv_left > 0) recv_left--;
      else if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(0, 3) == 0) recv_left = gap_len();
      else if ($urandom_range(0, 99) == 0) recv_calm = $urandom_range(50, 300);
      rsi_stall <= hold_active || (recv_left > 0);
    end
  end

  task automatic offer(input logic [rsi_pkg::CLOSE_BITS-1:0] c);
    close_backlog = {close_backlog, c};
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (close_backlog.size() != 0 || price_valid || rsi_due.size() != 0);
  endtask

  // a write restarts seeding, so the predictor clears with it
  task automatic write_period(input logic [rsi_pkg::PERIOD_BITS-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_period <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_len = v;
    prev_close = '0;
    seen_count = '0;
    avg_up = '0;
    avg_down = '0;
  endtask

  task automatic random_phase(input logic [rsi_pkg::PERIOD_BITS-1:0] per, input int count);
    int                             seg_left;
    int                             trend;
    int                             r;
    logic [rsi_pkg::CLOSE_BITS-1:0] mag;
    logic [rsi_pkg::CLOSE_BITS-1:0] step;
    logic [rsi_pkg::CLOSE_BITS-1:0] last;
    logic [rsi_pkg::CLOSE_BITS-1:0] c;
    logic                           rising;
    seg_left = 0;
    trend = 1;
    mag = 32'd15;
    write_period(per);
    @(negedge clk);
    last = $urandom;
    for (int i = 0; i < count; i++) begin
      // price walk in segments with their own drift and step size
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        trend = $urandom_range(0, 2);
        case ($urandom_range(0, 3))
          0: mag = 32'd15;
          1: mag = 32'd2000;
          2: mag = 32'h0010_0000;
          default: mag = 32'h7FFF_FFFF;
        endcase
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if (r < 5) c = $urandom;
      else if (r < 8) c = '0;
      else if (r < 11) c = '1;
      else if (r < 20) c = last;
      else begin
        step = $urandom_range(0, mag);
        if (trend == 2) rising = ($urandom_range(0, 9) < 8);
        else if (trend == 0) rising = ($urandom_range(0, 9) < 2);
        else rising = $urandom_range(0, 1);
        c = rising ? last + step : last - step;
      end
      last = c;
      offer(c);
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default period, never seeded
    @(negedge clk);
    offer(32'd0);
    offer(32'hFFFF_FFFF);
    offer(32'd7);
    wait_drained();

    // period one: full-scale swings and flat prices with zero loss
    write_period(8'd1);
    @(negedge clk);
    offer(32'd0);
    offer(32'hFFFF_FFFF);
    offer(32'd0);
    offer(32'd0);
    offer(32'd5);
    offer(32'd3);
    offer(32'd3);
    offer(32'd10);
    wait_drained();

    // zero period behaves as one
    write_period(8'd0);
    @(negedge clk);
    offer(32'd50);
    offer(32'd40);
    offer(32'd60);
    offer(32'd60);
    wait_drained();

    write_period(8'd3);
    @(negedge clk);
    offer(32'd1000);
    offer(32'd1010);
    offer(32'd990);
    offer(32'd1005);
    offer(32'd1005);
    offer(32'd980);
    offer(32'd1100);
    offer(32'd0);
    wait_drained();

    random_phase(8'd255, 330);
    random_phase(8'd1, 150);
    random_phase(8'd0, 100);
    random_phase(8'd2, 180);
    random_phase(rsi_pkg::PERIOD_RESET, 290);
    repeat (4) random_phase(rsi_pkg::PERIOD_BITS'($urandom_range(3, 40)), 175);

    // let the microcode settle before closing
    repeat (100) @(posedge clk);
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
